FILE: design/bflf_pkg.sv
package bflf_pkg;

  localparam int unsigned MaxLinks    = 16;
  localparam int unsigned FilterWords = 4;
  localparam int unsigned IdxW        = $clog2(MaxLinks);
  localparam int unsigned WordAddrW   = $clog2(MaxLinks * 4);

  localparam logic [15:0] EtNative = 16'd2058;
  localparam logic [15:0] EtSdn    = 16'd34525;
  localparam logic [4:0]  StripEth = 5'd14;
  localparam logic [4:0]  StripSdn = 5'd22;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_LOCAL = 2'd1,
    OP_NET   = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_FWD  = 2'd0,
    KIND_DLV  = 2'd1,
    KIND_DROP = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ACT_REWRITE = 3'd0,
    ACT_ADD_SDN = 3'd1,
    ACT_STRIP   = 3'd2,
    ACT_PUSH_NT = 3'd3,
    ACT_PUSH_SD = 3'd4,
    ACT_UNKNOWN = 3'd5
  } act_e;

  typedef enum logic [2:0] {
    CFG_LINKS = 3'd0,
    CFG_LID0  = 3'd1,
    CFG_LID1  = 3'd2,
    CFG_LID2  = 3'd3,
    CFG_LID3  = 3'd4
  } cfg_e;

  typedef enum logic [2:0] {
    WS_SRC  = 3'd4,
    WS_DST  = 3'd5,
    WS_PORT = 3'd6,
    WS_ET   = 3'd7
  } ws_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  out_port;
    logic [3:0]  link_index;
    logic [2:0]  action;
    logic [47:0] new_src_mac;
    logic [47:0] new_dst_mac;
    logic [15:0] new_ethertype;
    logic [4:0]  strip_bytes;
    logic        last;
  } res_t;

endpackage

FILE: design/bflf_ram.sv
module bflf_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: design/bflf_subset.sv
// One 64-bit subset compare per cycle while step_i is high, accumulated over the filter words.
module bflf_subset (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        step_i,
  input  logic [63:0] filter_i,
  input  logic [63:0] id_i,
  output logic        match_o
);

  logic match_q, match_d, hit;

  assign hit = ((filter_i & id_i) == id_i);

  always_comb begin
    match_d = match_q;
    if (start_i) begin
      match_d = 1'b1;
    end else if (step_i) begin
      match_d = match_q & hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b1;
    end else begin
      match_q <= match_d;
    end
  end

  assign match_o = match_q;

endmodule

FILE: design/bloom_filter_link_forwarder.sv
// A load request is taken without leaving the idle state. A packet walks N = min(links in use,
// MaxLinks) entries through one shared subset comparator and the single read port of the
// identifier RAM, one entry after another (N = 0 for a network packet with an all-ones filter);
// the input stalls until the packet's last result is registered. Forward results wait in a
// pending register before the output register; output stalls hold them back. Reset (rst_ni
// low, async) clears control and configuration; table contents are undefined until loaded.
module bloom_filter_link_forwarder (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            op_i,
  input  logic [3:0]            entry_index_i,
  input  logic [2:0]            word_select_i,
  input  logic [63:0]           load_value_i,
  input  logic [63:0]           filter_word0_i,
  input  logic [63:0]           filter_word1_i,
  input  logic [63:0]           filter_word2_i,
  input  logic [63:0]           filter_word3_i,
  input  logic [47:0]           packet_src_mac_i,
  input  logic [47:0]           packet_dst_mac_i,
  input  logic [15:0]           packet_ethertype_i,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_index_i,
  input  logic [63:0]           cfg_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            kind_o,
  output logic [3:0]            out_port_o,
  output logic [3:0]            link_index_o,
  output logic [2:0]            action_o,
  output logic [47:0]           new_src_mac_o,
  output logic [47:0]           new_dst_mac_o,
  output logic [15:0]           new_ethertype_o,
  output logic [4:0]            strip_bytes_o,
  output logic                  last_o
);
  import bflf_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_READ  = 7'b0000010,
    ST_CMP   = 7'b0000100,
    ST_EVAL  = 7'b0001000,
    ST_LOCAL = 7'b0010000,
    ST_FLUSH = 7'b0100000,
    ST_LAST  = 7'b1000000
  } state_e;

  typedef logic [IdxW:0] ent_t;

  state_e state_q, state_d;

  logic [4:0]  links_q;
  logic [63:0] lid_q [4];
  logic [63:0] flt_q [4];
  logic [1:0]  op_q;
  logic [47:0] psrc_q, pdst_q;
  logic [15:0] pet_q;
  ent_t        ent_q, ent_d;
  logic [1:0]  wrd_q, wrd_d;
  logic [1:0]  cw_q, cw_d;
  ent_t        walk;
  logic        any_q, any_d;
  logic        all_ones;

  logic [47:0] esrc_q [MaxLinks];
  logic [47:0] edst_q [MaxLinks];
  logic [3:0]  eport_q [MaxLinks];
  logic [15:0] eet_q [MaxLinks];

  res_t or_q, or_d;
  logic ov_q, ov_d;
  res_t pr_q, pr_d;
  logic pv_q, pv_d;
  res_t fwd;

  logic accept, ld, out_free, dlv, last_word;
  logic [WordAddrW-1:0] waddr, raddr;
  logic [63:0] id_word, cmp_filter, cmp_id;
  logic cmp_start, cmp_step, match;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept = in_valid_i && !in_stall_o;
  assign ld = accept && (op_i == OP_LOAD) && (word_select_i < 3'd4)
              && ({1'b0, word_select_i[1:0]} < 3'(FilterWords));

  assign waddr = {entry_index_i, word_select_i[1:0]};
  assign raddr = {ent_q[IdxW-1:0], wrd_q};

  bflf_ram #(.Width(64), .Depth(MaxLinks * 4)) u_id_ram (
    .clk_i,
    .we_i   (ld),
    .waddr_i(waddr),
    .wdata_i(load_value_i),
    .raddr_i(raddr),
    .rdata_o(id_word)
  );

  // Read data is registered, so the word compared is cw_q, which trails the read address wrd_q.
  assign cmp_filter = flt_q[cw_q];
  assign cmp_id     = (state_q == ST_LOCAL) ? lid_q[cw_q] : id_word;

  bflf_subset u_subset (
    .clk_i,
    .rst_ni,
    .start_i (cmp_start),
    .step_i  (cmp_step),
    .filter_i(cmp_filter),
    .id_i    (cmp_id),
    .match_o (match)
  );

  assign walk = ({1'b0, links_q} > 6'(MaxLinks)) ? ent_t'(MaxLinks) : ent_t'(links_q);

  always_comb begin
    all_ones = 1'b1;
    for (int w = 0; w < FilterWords; w++) begin
      if (flt_q[w] != '1) begin
        all_ones = 1'b0;
      end
    end
  end

  assign last_word = (cw_q == 2'(FilterWords - 1));
  assign out_free  = !ov_q || !out_stall_i;
  assign dlv       = (op_q == OP_NET) && match;

  // Entry evaluation
  logic [47:0] es, ed;
  logic [15:0] eet;
  logic        emit;
  logic [2:0]  act;
  logic [15:0] wet;
  assign es  = esrc_q[ent_q[IdxW-1:0]];
  assign ed  = edst_q[ent_q[IdxW-1:0]];
  assign eet = eet_q[ent_q[IdxW-1:0]];

  always_comb begin
    emit = match;
    act  = ACT_REWRITE;
    wet  = '0;
    if (op_q == OP_LOCAL) begin
      if (eet == EtNative) begin
        act = ACT_PUSH_NT;
        wet = eet;
      end else if (eet == EtSdn) begin
        act = ACT_PUSH_SD;
        wet = eet;
      end else begin
        emit = 1'b0;
      end
    end else begin
      if ((psrc_q == ed && pdst_q == es) || psrc_q == es || pdst_q == ed) begin
        emit = 1'b0;
      end
      if (pet_q == eet) begin
        act = ACT_REWRITE;
      end else if (pet_q == EtNative && eet == EtSdn) begin
        act = ACT_ADD_SDN;
        wet = eet;
      end else if (pet_q == EtSdn && eet == EtNative) begin
        act = ACT_STRIP;
        wet = eet;
      end else begin
        act = ACT_UNKNOWN;
      end
    end
  end

  always_comb begin
    fwd = '0;
    fwd.kind = KIND_FWD;
    fwd.out_port = eport_q[ent_q[IdxW-1:0]];
    fwd.link_index = ent_q[IdxW-1:0];
    fwd.action = act;
    fwd.new_src_mac = es;
    fwd.new_dst_mac = ed;
    fwd.new_ethertype = wet;
  end

  always_comb begin
    state_d   = state_q;
    ent_d     = ent_q;
    wrd_d     = wrd_q;
    cw_d      = cw_q;
    any_d     = any_q;
    cmp_start = 1'b0;
    cmp_step  = 1'b0;
    ov_d      = ov_q && out_stall_i;
    or_d      = or_q;
    pv_d      = pv_q;
    pr_d      = pr_q;
    unique case (state_q)
      ST_IDLE: begin
        ent_d = '0;
        wrd_d = '0;
        cw_d  = '0;
        any_d = 1'b0;
        if (accept && (op_i == OP_LOCAL || op_i == OP_NET)) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        // End the walk after the last entry in use, or at once for a network packet with an all-ones filter.
        cmp_start = 1'b1;
        cw_d = '0;
        if (ent_q >= walk || (op_q == OP_NET && all_ones)) begin
          state_d = ST_LOCAL;
        end else begin
          wrd_d = 2'd1;
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        cmp_step = 1'b1;
        if (last_word) begin
          wrd_d = '0;
          state_d = ST_EVAL;
        end else begin
          wrd_d = wrd_q + 2'd1;
          cw_d  = cw_q + 2'd1;
        end
      end
      ST_EVAL: begin
        // Hold a new forward until the pending one can move to the output.
        if (!emit || !pv_q || out_free) begin
          if (emit) begin
            if (pv_q) begin
              ov_d = 1'b1;
              or_d = pr_q;
            end
            pr_d  = fwd;
            pv_d  = 1'b1;
            any_d = 1'b1;
          end
          ent_d = ent_t'(ent_q + 1'b1);
          state_d = ST_READ;
        end
      end
      ST_LOCAL: begin
        if (op_q != OP_NET) begin
          state_d = ST_FLUSH;
        end else begin
          cmp_step = 1'b1;
          if (last_word) begin
            state_d = ST_FLUSH;
          end else begin
            cw_d = cw_q + 2'd1;
          end
        end
      end
      ST_FLUSH: begin
        if (!pv_q) begin
          state_d = ST_LAST;
        end else if (out_free) begin
          ov_d = 1'b1;
          or_d = pr_q;
          or_d.last = !dlv;
          pv_d = 1'b0;
          state_d = dlv ? ST_LAST : ST_IDLE;
        end
      end
      ST_LAST: begin
        if (dlv || !any_q) begin
          if (out_free) begin
            ov_d = 1'b1;
            or_d = '0;
            if (dlv) begin
              or_d.kind = KIND_DLV;
              or_d.strip_bytes = (pet_q == EtSdn) ? StripSdn : StripEth;
            end else begin
              or_d.kind = KIND_DROP;
            end
            or_d.last = 1'b1;
            state_d = ST_IDLE;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ent_q   <= '0;
      wrd_q   <= '0;
      cw_q    <= '0;
      any_q   <= 1'b0;
      ov_q    <= 1'b0;
      or_q    <= '0;
      pv_q    <= 1'b0;
      pr_q    <= '0;
      links_q <= '0;
      for (int i = 0; i < 4; i++) begin
        lid_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      ent_q   <= ent_d;
      wrd_q   <= wrd_d;
      cw_q    <= cw_d;
      any_q   <= any_d;
      ov_q    <= ov_d;
      or_q    <= or_d;
      pv_q    <= pv_d;
      pr_q    <= pr_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_LINKS: links_q  <= cfg_data_i[4:0];
          CFG_LID0:  lid_q[0] <= cfg_data_i;
          CFG_LID1:  lid_q[1] <= cfg_data_i;
          CFG_LID2:  lid_q[2] <= cfg_data_i;
          CFG_LID3:  lid_q[3] <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= op_i;
      flt_q[0] <= filter_word0_i;
      flt_q[1] <= filter_word1_i;
      flt_q[2] <= filter_word2_i;
      flt_q[3] <= filter_word3_i;
      psrc_q <= packet_src_mac_i;
      pdst_q <= packet_dst_mac_i;
      pet_q  <= packet_ethertype_i;
      if (op_i == OP_LOAD) begin
        unique case (word_select_i)
          WS_SRC:  esrc_q[entry_index_i]  <= load_value_i[47:0];
          WS_DST:  edst_q[entry_index_i]  <= load_value_i[47:0];
          WS_PORT: eport_q[entry_index_i] <= load_value_i[3:0];
          WS_ET:   eet_q[entry_index_i]   <= load_value_i[15:0];
          default: ;
        endcase
      end
    end
  end

  assign out_valid_o     = ov_q;
  assign kind_o          = or_q.kind;
  assign out_port_o      = or_q.out_port;
  assign link_index_o    = or_q.link_index;
  assign action_o        = or_q.action;
  assign new_src_mac_o   = or_q.new_src_mac;
  assign new_dst_mac_o   = or_q.new_dst_mac;
  assign new_ethertype_o = or_q.new_ethertype;
  assign strip_bytes_o   = or_q.strip_bytes;
  assign last_o          = or_q.last;

endmodule

FILE: sim/bflf_checker.sv
`timescale 1ns / 100ps

module bflf_checker
  import bflf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  op_i,
  input  logic [3:0]  entry_index_i,
  input  logic [2:0]  word_select_i,
  input  logic [63:0] load_value_i,
  input  logic [63:0] filter_word0_i,
  input  logic [63:0] filter_word1_i,
  input  logic [63:0] filter_word2_i,
  input  logic [63:0] filter_word3_i,
  input  logic [47:0] packet_src_mac_i,
  input  logic [47:0] packet_dst_mac_i,
  input  logic [15:0] packet_ethertype_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  kind_i,
  input  logic [3:0]  out_port_i,
  input  logic [3:0]  link_index_i,
  input  logic [2:0]  action_i,
  input  logic [47:0] new_src_mac_i,
  input  logic [47:0] new_dst_mac_i,
  input  logic [15:0] new_ethertype_i,
  input  logic [4:0]  strip_bytes_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          pending_o
);

  logic [63:0] id_words [MaxLinks*4];
  logic [47:0] ent_src [MaxLinks];
  logic [47:0] ent_dst [MaxLinks];
  logic [3:0]  ent_port [MaxLinks];
  logic [15:0] ent_et [MaxLinks];
  logic [4:0]  walk_len;
  logic [255:0] local_id;
  res_t        route_q[$];

  task automatic report(input string name, input logic [63:0] exp, input logic [63:0] got);
    if (exp !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, got);
      fail_count_o++;
    end
  endtask

  task automatic route_packet();
    logic [255:0] flt;
    logic [255:0] ent_id;
    logic         all_ones;
    int           n;
    int           cnt;
    res_t         outs[18];
    logic [2:0]   act;
    logic [15:0]  wet;
    logic [47:0]  es, ed;
    logic [15:0]  eet;
    flt = {filter_word3_i, filter_word2_i, filter_word1_i, filter_word0_i};
    all_ones = &flt;
    n = (walk_len > MaxLinks) ? MaxLinks : walk_len;
    cnt = 0;
    for (int e = 0; e < n; e++) begin
      ent_id = {id_words[e*4+3], id_words[e*4+2], id_words[e*4+1], id_words[e*4]};
      if ((flt & ent_id) != ent_id) continue;
      es = ent_src[e];
      ed = ent_dst[e];
      eet = ent_et[e];
      if (op_i == OP_LOCAL) begin
        if (eet == EtNative) act = ACT_PUSH_NT;
        else if (eet == EtSdn) act = ACT_PUSH_SD;
        else continue;
        wet = eet;
      end else begin
        if (all_ones) break;
        // skip loop links
        if ((packet_src_mac_i == ed && packet_dst_mac_i == es) ||
            packet_src_mac_i == es || packet_dst_mac_i == ed) continue;
        if (packet_ethertype_i == eet) begin
          act = ACT_REWRITE; wet = '0;
        end else if (packet_ethertype_i == EtNative && eet == EtSdn) begin
          act = ACT_ADD_SDN; wet = eet;
        end else if (packet_ethertype_i == EtSdn && eet == EtNative) begin
          act = ACT_STRIP; wet = eet;
        end else begin
          act = ACT_UNKNOWN; wet = '0;
        end
      end
      outs[cnt] = '0;
      outs[cnt].kind = KIND_FWD;
      outs[cnt].out_port = ent_port[e];
      outs[cnt].link_index = e[3:0];
      outs[cnt].action = act;
      outs[cnt].new_src_mac = es;
      outs[cnt].new_dst_mac = ed;
      outs[cnt].new_ethertype = wet;
      cnt++;
    end
    if (op_i == OP_NET && (flt & local_id) == local_id) begin
      outs[cnt] = '0;
      outs[cnt].kind = KIND_DLV;
      outs[cnt].strip_bytes = (packet_ethertype_i == EtSdn) ? StripSdn : StripEth;
      cnt++;
    end
    if (cnt == 0) begin
      outs[0] = '0;
      outs[0].kind = KIND_DROP;
      cnt = 1;
    end
    outs[cnt-1].last = 1'b1;
    for (int i = 0; i < cnt; i++) route_q = {route_q, outs[i]};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_len <= '0;
      local_id <= '0;
      route_q.delete();
      fail_count_o = 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (route_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0h", $time,
                   {kind_i, out_port_i, link_index_i, action_i, new_src_mac_i,
                    new_dst_mac_i, new_ethertype_i, strip_bytes_i, last_i});
          fail_count_o++;
        end else begin
          report("kind", 64'(route_q[0].kind), 64'(kind_i));
          report("out_port", 64'(route_q[0].out_port), 64'(out_port_i));
          report("link_index", 64'(route_q[0].link_index), 64'(link_index_i));
          report("action", 64'(route_q[0].action), 64'(action_i));
          report("new_src_mac", 64'(route_q[0].new_src_mac), 64'(new_src_mac_i));
          report("new_dst_mac", 64'(route_q[0].new_dst_mac), 64'(new_dst_mac_i));
          report("new_ethertype", 64'(route_q[0].new_ethertype), 64'(new_ethertype_i));
          report("strip_bytes", 64'(route_q[0].strip_bytes), 64'(strip_bytes_i));
          report("last", 64'(route_q[0].last), 64'(last_i));
          void'(route_q.pop_front());
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_LINKS: walk_len <= cfg_data_i[4:0];
          CFG_LID0:  local_id[63:0] <= cfg_data_i;
          CFG_LID1:  local_id[127:64] <= cfg_data_i;
          CFG_LID2:  local_id[191:128] <= cfg_data_i;
          CFG_LID3:  local_id[255:192] <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        if (op_i == OP_LOAD) begin
          case (word_select_i)
            WS_SRC:  ent_src[entry_index_i] = load_value_i[47:0];
            WS_DST:  ent_dst[entry_index_i] = load_value_i[47:0];
            WS_PORT: ent_port[entry_index_i] = load_value_i[3:0];
            WS_ET:   ent_et[entry_index_i] = load_value_i[15:0];
            default: id_words[{entry_index_i, word_select_i[1:0]}] = load_value_i;
          endcase
        end else if (op_i != OP_NONE) begin
          route_packet();
        end
      end
      pending_o <= route_q.size();
    end
  end

endmodule

FILE: sim/bloom_filter_link_forwarder_test.sv
`timescale 1ns / 100ps

module bloom_filter_link_forwarder_test;
  import bflf_pkg::*;

  localparam int CycleLimit = 1000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  op = OP_LOAD;
  logic [3:0]  entry_index = '0;
  logic [2:0]  word_select = '0;
  logic [63:0] load_value = '0;
  logic [255:0] filter = '0;
  logic [47:0] pkt_src = '0;
  logic [47:0] pkt_dst = '0;
  logic [15:0] pkt_et = '0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = CFG_LINKS;
  logic [63:0] cfg_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  kind;
  logic [3:0]  out_port, link_index;
  logic [2:0]  action;
  logic [47:0] new_src_mac, new_dst_mac;
  logic [15:0] new_ethertype;
  logic [4:0]  strip_bytes;
  logic        last;
  int          fail_count, pending;
  int          cycles = 0;
  bit          long_hold = 0;
  bit          hold_done = 0;
  int          hold_cnt = 0;

  logic [255:0] link_ids [MaxLinks];
  logic [47:0]  mac_pool [6];
  logic [255:0] lid_shadow;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  bloom_filter_link_forwarder uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .op_i(op), .entry_index_i(entry_index), .word_select_i(word_select),
    .load_value_i(load_value),
    .filter_word0_i(filter[63:0]), .filter_word1_i(filter[127:64]),
    .filter_word2_i(filter[191:128]), .filter_word3_i(filter[255:192]),
    .packet_src_mac_i(pkt_src), .packet_dst_mac_i(pkt_dst),
    .packet_ethertype_i(pkt_et),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .kind_o(kind), .out_port_o(out_port), .link_index_o(link_index),
    .action_o(action), .new_src_mac_o(new_src_mac), .new_dst_mac_o(new_dst_mac),
    .new_ethertype_o(new_ethertype), .strip_bytes_o(strip_bytes), .last_o(last)
  );

  bflf_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .op_i(op), .entry_index_i(entry_index), .word_select_i(word_select),
    .load_value_i(load_value),
    .filter_word0_i(filter[63:0]), .filter_word1_i(filter[127:64]),
    .filter_word2_i(filter[191:128]), .filter_word3_i(filter[255:192]),
    .packet_src_mac_i(pkt_src), .packet_dst_mac_i(pkt_dst),
    .packet_ethertype_i(pkt_et),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .kind_i(kind), .out_port_i(out_port), .link_index_i(link_index),
    .action_i(action), .new_src_mac_i(new_src_mac), .new_dst_mac_i(new_dst_mac),
    .new_ethertype_i(new_ethertype), .strip_bytes_i(strip_bytes), .last_i(last),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver backpressure; one long hold-off when requested
  always @(posedge clk) begin
    if (long_hold && !hold_done) begin
      hold_done = 1;
      hold_cnt = 400;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < 70) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 90) || ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 49) == 0) hold_cnt = $urandom_range(10, 30);
    end
  end

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [255:0] sparse_id();
    logic [255:0] v;
    for (int i = 0; i < 4; i++) v[i*64 +: 64] = rnd64() & rnd64() & rnd64() & rnd64();
    return v;
  endfunction

  function automatic logic [15:0] pick_et();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return EtNative;
    if (r < 8) return EtSdn;
    return 16'($urandom);
  endfunction

  function automatic logic [47:0] pick_mac();
    if ($urandom_range(0, 4) == 0) return 48'({$urandom, $urandom});
    return mac_pool[$urandom_range(0, 5)];
  endfunction

  task automatic send_item(input logic [1:0] o, input logic [3:0] ei, input logic [2:0] ws,
                           input logic [63:0] lv, input logic [255:0] flt,
                           input logic [47:0] ps, input logic [47:0] pd,
                           input logic [15:0] pe);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    op <= o;
    entry_index <= ei;
    word_select <= ws;
    load_value <= lv;
    filter <= flt;
    pkt_src <= ps;
    pkt_dst <= pd;
    pkt_et <= pe;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (o == OP_LOAD && ws < 4) link_ids[ei][ws[1:0]*64 +: 64] = lv;
  endtask

  task automatic load_word(input logic [3:0] ei, input logic [2:0] ws, input logic [63:0] lv);
    send_item(OP_LOAD, ei, ws, lv, 256'(rnd64()), pick_mac(), pick_mac(), 16'($urandom));
  endtask

  task automatic load_entry(input logic [3:0] ei);
    logic [255:0] id;
    id = sparse_id();
    for (int w = 0; w < 4; w++) load_word(ei, 3'(w), id[w*64 +: 64]);
    load_word(ei, WS_SRC, {16'($urandom_range(0, 65535)), pick_mac()});
    load_word(ei, WS_DST, {16'hffff, pick_mac()});
    load_word(ei, WS_PORT, rnd64());
    load_word(ei, WS_ET, {48'(rnd64() >> 16), pick_et()});
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [2:0] idx, input logic [63:0] val);
    in_valid <= 1'b0;
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx != CFG_LINKS) lid_shadow[(idx - 1) * 64 +: 64] = val;
  endtask

  task automatic set_local_id(input logic [255:0] v);
    for (int w = 0; w < 4; w++) write_cfg(3'(int'(CFG_LID0) + w), v[w*64 +: 64]);
  endtask

  task automatic rand_packet();
    logic [255:0] flt;
    logic [47:0]  ps, pd;
    logic [1:0]   o;
    int r, e;
    r = $urandom_range(0, 99);
    o = (r < 30) ? OP_LOCAL : (r < 97) ? OP_NET : OP_NONE;
    flt = '0;
    repeat ($urandom_range(0, 4)) flt |= link_ids[$urandom_range(0, MaxLinks - 1)];
    if ($urandom_range(0, 2) == 0) flt |= sparse_id();
    if ($urandom_range(0, 2) == 0) flt |= lid_shadow;
    r = $urandom_range(0, 19);
    if (r == 0) flt = '1;
    else if (r == 1) flt = {rnd64(), rnd64(), rnd64(), rnd64()};
    ps = pick_mac();
    pd = pick_mac();
    // now and then add one more link ID to the filter
    if ($urandom_range(0, 3) == 0) begin
      e = $urandom_range(0, MaxLinks - 1);
      flt |= link_ids[e];
    end
    send_item(o, 4'($urandom), 3'($urandom), rnd64(), flt, ps, pd, pick_et());
  endtask

  task automatic rand_phase(input int items);
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(0, 99) < 20) begin
        if ($urandom_range(0, 3) == 0) load_word(4'($urandom), 3'($urandom), rnd64());
        else load_entry(4'($urandom));
      end else begin
        rand_packet();
      end
    end
  endtask

  initial begin
    mac_pool[0] = '0;
    mac_pool[1] = '1;
    for (int i = 2; i < 6; i++) mac_pool[i] = 48'({$urandom, $urandom});
    lid_shadow = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill the whole table before any walk reads it
    for (int e = 0; e < MaxLinks; e++) load_entry(4'(e));
    write_cfg(CFG_LINKS, 64'(16));

    // directed: masking of loads, every op, loop links, all-ones filter
    load_word(0, WS_PORT, '1);
    load_word(0, WS_ET, {48'hffff_ffff_ffff, EtNative});
    load_word(1, WS_ET, {48'h0, EtSdn});
    load_word(2, WS_ET, 64'h1234);
    load_word(3, WS_SRC, '1);
    load_word(3, WS_DST, 64'h0);
    load_word(15, 3'd3, '0);
    send_item(OP_LOCAL, 0, 0, 0, '1, 0, 0, 0);
    send_item(OP_LOCAL, 0, 0, 0, '0, 0, 0, 0);
    send_item(OP_NET, 0, 0, 0, '1, '1, '1, EtSdn);
    send_item(OP_NET, 0, 0, 0, '0, 0, 0, EtNative);
    send_item(OP_NET, 0, 0, 0, link_ids[0] | link_ids[1] | link_ids[2], 1, 2, EtNative);
    send_item(OP_NET, 0, 0, 0, link_ids[0] | link_ids[1] | link_ids[2], 1, 2, EtSdn);
    send_item(OP_NET, 0, 0, 0, link_ids[0] | link_ids[1], 1, 2, 16'h1234);
    send_item(OP_NET, 0, 0, 0, link_ids[2], 5, 6, 16'h1234);
    send_item(OP_NET, 0, 0, 0, link_ids[3], 48'h0, '1, EtNative);
    send_item(OP_NET, 0, 0, 0, link_ids[3], '1, 48'h5, EtNative);
    send_item(OP_NET, 0, 0, 0, link_ids[3], 48'h7, 48'h0, EtNative);
    send_item(OP_NONE, 0, 0, 0, '1, 0, 0, 0);
    send_item(OP_NET, 0, 0, 0, {4{rnd64()}}, '1, 0, 16'hffff);
    wait_idle();

    set_local_id('1);
    write_cfg(CFG_LINKS, 64'(0));
    send_item(OP_NET, 0, 0, 0, '1, 1, 2, EtSdn);
    send_item(OP_LOCAL, 0, 0, 0, '1, 1, 2, EtSdn);
    send_item(OP_NET, 0, 0, 0, '0, 1, 2, EtNative);
    wait_idle();

    set_local_id(sparse_id());
    write_cfg(CFG_LINKS, 64'(16));
    rand_phase(12);
    wait_idle();

    write_cfg(CFG_LINKS, 64'($urandom_range(1, 6)));
    set_local_id('0);
    long_hold = 1;
    rand_phase(12);
    wait_idle();

    write_cfg(CFG_LINKS, 64'(1));
    set_local_id(sparse_id());
    rand_phase(8);
    wait_idle();

    write_cfg(CFG_LINKS, 64'(31));
    rand_phase(8);
    wait_idle();

    write_cfg(CFG_LINKS, 64'($urandom_range(0, 16)));
    rand_phase(10);
    wait_idle();

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
